// ===== rtl/lkv_pkg.sv =====
// Shared constants and types of the LRU key/value cache.
// No dependencies; every other file of the block but lkv_checker uses this package.
package lkv_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int              CFG_BITS  = 5;
	localparam logic [CFG_BITS-1:0] CAP_RESET = CFG_BITS'(16);

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	// update command broadcast from the control to every cell
	typedef struct packed {
		logic put;        // request in flight is a put
		logic shift_hit;  // move the hit entry to the head, shift cells ahead of it
		logic shift_all;  // insert at the head, shift the whole row
	} lkv_cmd_t;

endpackage

// ===== rtl/lkv_ifs.sv =====
// Request and response channel interfaces of the LRU key/value cache.
// Depends on lkv_pkg for default field widths.
interface lkv_req_if #(
	parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic signed [KEY_BITS-1:0]   key;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, req_type, key, value, input ready);
	modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lkv_rsp_if #(
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic signed [VALUE_BITS-1:0] read_value;
	logic                         evicted;

	modport source (output valid, hit, read_value, evicted, input ready);
	modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

// ===== rtl/lkv_cell.sv =====
// One recency slot of the cache row: holds a key and value, compares the
// lookup key, and takes its left neighbor's entry when the row shifts. Uses lkv_pkg.
module lkv_cell #(
	parameter int INDEX      = 0,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int IDX_BITS   = 4,
	parameter int CNT_BITS   = 5
) (
	input  logic                  clk,
	input  lkv_pkg::lkv_cmd_t     cmd,
	input  logic [IDX_BITS-1:0]   hit_idx,
	input  logic [CNT_BITS-1:0]   used,
	input  logic [KEY_BITS-1:0]   lookup_key,
	input  logic [KEY_BITS-1:0]   left_key,
	input  logic [VALUE_BITS-1:0] left_value,
	output logic [KEY_BITS-1:0]   key_q,
	output logic [VALUE_BITS-1:0] value_q,
	output logic                  match
);
	import lkv_pkg::*;

	logic take;

	assign take  = cmd.shift_all || (cmd.shift_hit && (hit_idx >= IDX_BITS'(INDEX)));
	assign match = (CNT_BITS'(INDEX) < used) && (key_q == lookup_key);

	always_ff @(posedge clk) begin
		if (take) begin
			key_q   <= left_key;
			value_q <= left_value;
		end
	end

endmodule

// ===== rtl/lkv_ctrl.sv =====
// Control of the LRU key/value cache: capacity register, entry count,
// request tracking and the response register. Uses lkv_pkg.
module lkv_ctrl #(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32,
	parameter int CNT_BITS   = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lkv_pkg::CFG_BITS-1:0]  cfg_wdata,
	input  logic                          accept,
	input  logic                          req_type,
	input  logic                          any_match,
	input  logic [VALUE_BITS-1:0]         hit_value_s1,
	input  logic                          out_ready,
	output logic                          in_ready,
	output lkv_pkg::lkv_cmd_t             cmd,
	output logic [CNT_BITS-1:0]           used,
	output logic                          out_valid,
	output logic                          out_hit,
	output logic [VALUE_BITS-1:0]         out_read_value,
	output logic                          out_evicted
);
	import lkv_pkg::*;

	localparam int CMPW = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

	logic [CFG_BITS-1:0]   cap_q;
	logic [CNT_BITS-1:0]   used_q;
	logic [CNT_BITS-1:0]   cap_eff;
	logic [CMPW-1:0]       cap_w;
	logic                  busy_q;
	logic                  put_s1;
	logic                  hit_s1;
	logic                  out_valid_q;
	logic                  fire;
	logic                  full;

	always_comb begin
		cap_w = CMPW'(cap_q);
		if (cap_w == '0)
			cap_eff = CNT_BITS'(1);
		else if (cap_w > CMPW'(DEPTH))
			cap_eff = CNT_BITS'(DEPTH);
		else
			cap_eff = CNT_BITS'(cap_w);
	end

	assign full = (used_q >= cap_eff);
	assign fire = busy_q && (!out_valid_q || out_ready);

	assign cmd.put       = put_s1;
	assign cmd.shift_hit = fire && hit_s1;
	assign cmd.shift_all = fire && put_s1 && !hit_s1;

	assign in_ready  = !busy_q;
	assign used      = used_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			used_q      <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (cmd.shift_all && !full)
				used_q <= used_q + CNT_BITS'(1);
			if (accept)
				busy_q <= 1'b1;
			else if (fire)
				busy_q <= 1'b0;
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			put_s1 <= (req_type == REQ_PUT);
			hit_s1 <= any_match;
		end
		if (fire) begin
			out_hit     <= hit_s1;
			out_evicted <= put_s1 && !hit_s1 && full;
			if (put_s1)
				out_read_value <= '0;
			else if (hit_s1)
				out_read_value <= hit_value_s1;
			else
				out_read_value <= '1;
		end
	end

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement.
// Built from lkv_ctrl and a row of lkv_cell; uses lkv_pkg and the channel interfaces.
//
// Usage:
//   req: get (req_type 0) or put (req_type 1) beats with key and value.
//   rsp: one beat per request: hit, read_value (stored value on a get hit,
//        all ones on a get miss, zero on a put) and evicted.
//   cfg_we/cfg_wdata: capacity in use; write only while no request is open.
// The row keeps entries ordered by recency: cell 0 is the most recent. A
// request's key is compared against every cell at the edge that accepts it;
// once the response register is free, the row shifts toward the tail and the
// response register loads at the same edge. A new request is taken only after
// the previous one has updated the row, set by the compare then shift of the row.
// A response that waits on rsp.ready holds the row update back; one further
// request may be accepted behind it.
// Reset empties the cache at once (entry count cleared) and sets capacity
// to 16; key and value storage needs no clearing.
module lru_key_value_cache #(
	parameter int DEPTH      = lkv_pkg::DEPTH_DEF,
	parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lkv_req_if.sink                      req,
	lkv_rsp_if.source                    rsp,
	input  logic                         cfg_we,
	input  logic [lkv_pkg::CFG_BITS-1:0] cfg_wdata
);
	import lkv_pkg::*;

	localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	lkv_cmd_t              cmd;
	logic [CNT_BITS-1:0]   used;
	logic                  accept;
	logic                  any_match;
	logic [IDX_BITS-1:0]   hit_idx_c;
	logic [VALUE_BITS-1:0] hit_value_c;
	logic [IDX_BITS-1:0]   hit_idx_s1;
	logic [VALUE_BITS-1:0] hit_value_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [VALUE_BITS-1:0] head_value;

	logic [DEPTH-1:0]      match;
	logic [KEY_BITS-1:0]   cell_key   [DEPTH];
	logic [VALUE_BITS-1:0] cell_value [DEPTH];
	logic [KEY_BITS-1:0]   left_key   [DEPTH];
	logic [VALUE_BITS-1:0] left_value [DEPTH];

	assign accept     = req.valid && req.ready;
	assign head_value = cmd.put ? value_s1 : hit_value_s1;

	always_comb begin
		any_match   = 1'b0;
		hit_idx_c   = '0;
		hit_value_c = '0;
		for (int i = 0; i < DEPTH; i++) begin
			any_match   = any_match | match[i];
			hit_idx_c   = hit_idx_c | (match[i] ? IDX_BITS'(i) : '0);
			hit_value_c = hit_value_c | (match[i] ? cell_value[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1       <= req.key;
			value_s1     <= req.value;
			hit_idx_s1   <= hit_idx_c;
			hit_value_s1 <= hit_value_c;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_key[i]   = key_s1;
			assign left_value[i] = head_value;
		end else begin : g_link
			assign left_key[i]   = cell_key[i-1];
			assign left_value[i] = cell_value[i-1];
		end

		lkv_cell #(
			.INDEX      (i),
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.IDX_BITS   (IDX_BITS),
			.CNT_BITS   (CNT_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.hit_idx    (hit_idx_s1),
			.used       (used),
			.lookup_key (req.key),
			.left_key   (left_key[i]),
			.left_value (left_value[i]),
			.key_q      (cell_key[i]),
			.value_q    (cell_value[i]),
			.match      (match[i])
		);
	end

	lkv_ctrl #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.CNT_BITS   (CNT_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.accept         (accept),
		.req_type       (req.req_type),
		.any_match      (any_match),
		.hit_value_s1   (hit_value_s1),
		.out_ready      (rsp.ready),
		.in_ready       (req.ready),
		.cmd            (cmd),
		.used           (used),
		.out_valid      (rsp.valid),
		.out_hit        (rsp.hit),
		.out_read_value (rsp.read_value),
		.out_evicted    (rsp.evicted)
	);

endmodule

// ===== rtl/lkv_checker.sv =====
// Port-level assertions of the LRU key/value cache, bound to the top level.
// Depends on lru_key_value_cache and its channel interfaces.
module lkv_checker #(
	parameter int VALUE_BITS = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  rsp_hit,
	input logic [VALUE_BITS-1:0] rsp_read_value,
	input logic                  rsp_evicted
);

	// one request in flight: no beat right after an accepted one
	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one still open");

	// a fresh response follows an open request
	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without an open request");

	// eviction only on a put that missed
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_evicted |-> !rsp_hit && rsp_read_value == '0)
		else $error("eviction reported on a hit or with nonzero data");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
			$stable(rsp_read_value) && $stable(rsp_evicted))
		else $error("stalled response beat changed");

endmodule

bind lru_key_value_cache lkv_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_lkv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_hit        (rsp.hit),
	.rsp_read_value (rsp.read_value),
	.rsp_evicted    (rsp.evicted)
);

// ===== bench/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lru_key_value_cache: directed rows, then random get/put traffic.
// Uses lkv_pkg and the lkv_req_if / lkv_rsp_if channel interfaces from the RTL.
module lru_key_value_cache_tb;

	localparam int DEPTH       = lkv_pkg::DEPTH_DEF;
	localparam int KEY_W       = lkv_pkg::KEY_BITS_DEF;
	localparam int VAL_W       = lkv_pkg::VALUE_BITS_DEF;
	localparam int CAP_W       = lkv_pkg::CFG_BITS;
	localparam int AGE_W       = $clog2(DEPTH);
	localparam int SEG_ITEMS   = 65;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SRC_IDLE [3] = '{21, 59, 0};
	localparam int SNK_IDLE [3] = '{59, 21, 0};

	localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [KEY_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
	} lookup_result_t;

	typedef enum logic [1:0] {ROW_GET, ROW_PUT, ROW_CAP} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic             known;
		lookup_result_t   want;
	} stim_row_t;

	localparam lookup_result_t RES_NONE    = '0;
	localparam lookup_result_t RES_MISS    = '{1'b0, 32'hFFFF_FFFF, 1'b0};
	localparam lookup_result_t RES_STORED  = '{1'b0, 32'h0, 1'b0};
	localparam lookup_result_t RES_UPDATED = '{1'b1, 32'h0, 1'b0};
	localparam lookup_result_t RES_EVICT   = '{1'b0, 32'h0, 1'b1};

	localparam stim_row_t DIRECTED_ROWS [24] = '{
		'{ROW_GET, 32'h0,       32'h5A5A_5A5A, 1'b1, RES_MISS},
		'{ROW_PUT, KEY_MAX,     KEY_MIN,       1'b1, RES_STORED},
		'{ROW_PUT, KEY_MIN,     KEY_MAX,       1'b1, RES_STORED},
		'{ROW_GET, KEY_MAX,     32'h0,         1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
		'{ROW_PUT, KEY_MIN,     ALL_ONES,      1'b1, RES_UPDATED},
		'{ROW_GET, KEY_MIN,     32'h1234_5678, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
		'{ROW_PUT, 32'h0,       32'h0,         1'b1, RES_STORED},
		'{ROW_PUT, ALL_ONES,    32'h1,         1'b1, RES_STORED},
		'{ROW_CAP, 32'h0,       32'd0,         1'b0, RES_NONE},
		'{ROW_PUT, 32'd5,       32'd5,         1'b1, RES_EVICT},
		'{ROW_GET, KEY_MAX,     32'h0,         1'b1, RES_MISS},
		'{ROW_PUT, 32'd6,       32'd6,         1'b1, RES_EVICT},
		'{ROW_GET, 32'h0,       ALL_ONES,      1'b0, RES_NONE},
		'{ROW_GET, 32'd5,       32'h0,         1'b0, RES_NONE},
		'{ROW_CAP, 32'h0,       32'd31,        1'b0, RES_NONE},
		'{ROW_PUT, 32'd7,       32'd7,         1'b1, RES_STORED},
		'{ROW_CAP, 32'h0,       32'd2,         1'b0, RES_NONE},
		'{ROW_GET, ALL_ONES,    32'h0,         1'b0, RES_NONE},
		'{ROW_PUT, 32'd8,       32'd8,         1'b1, RES_EVICT},
		'{ROW_GET, 32'd6,       32'h0,         1'b1, RES_MISS},
		'{ROW_CAP, 32'h0,       32'd16,        1'b0, RES_NONE},
		'{ROW_PUT, KEY_MAX,     32'h0,         1'b0, RES_NONE},
		'{ROW_GET, ALL_ONES,    32'hA5A5_A5A5, 1'b0, RES_NONE},
		'{ROW_GET, 32'd8,       32'h0,         1'b0, RES_NONE}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	lkv_req_if req_if ();
	lkv_rsp_if rsp_if ();

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [KEY_W-1:0] cache_keys [DEPTH];
	logic [VAL_W-1:0] cache_vals [DEPTH];
	logic             cache_live [DEPTH];
	logic [AGE_W-1:0] cache_age  [DEPTH];
	logic [CAP_W-1:0] cache_fill;
	logic [CAP_W-1:0] cache_cap;

	lookup_result_t pending_results [$];
	int             error_count = 0;
	int             beat_count = 0;
	int             cycle_count = 0;
	int             src_idle_pct = 0;
	int             snk_idle_pct = 0;
	logic           hold_request = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[lru_key_value_cache] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < 100)
			$display("mismatch at response beat %0d: %s", beat_count, msg);
		error_count++;
	endtask

	function automatic lookup_result_t predict_access(input logic is_put,
			input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
		lookup_result_t   res;
		int               slot;
		int               oldest;
		int               hole;
		logic [AGE_W-1:0] prior;
		logic [CAP_W-1:0] limit;
		res = '0;
		slot = -1;
		oldest = -1;
		hole = -1;
		for (int j = 0; j < DEPTH; j++)
			if (slot < 0 && cache_live[j] && cache_keys[j] == k)
				slot = j;
		if (slot >= 0) begin
			res.hit = 1'b1;
			if (is_put)
				cache_vals[slot] = v;
			else
				res.read_value = cache_vals[slot];
			prior = cache_age[slot];
			for (int j = 0; j < DEPTH; j++)
				if (cache_live[j] && cache_age[j] < prior)
					cache_age[j] = cache_age[j] + AGE_W'(1);
			cache_age[slot] = '0;
		end else if (!is_put) begin
			res.read_value = '1;
		end else begin
			limit = (cache_cap == 0) ? CAP_W'(1) : (cache_cap > DEPTH) ? CAP_W'(DEPTH) : cache_cap;
			if (cache_fill >= limit) begin
				for (int j = 0; j < DEPTH; j++)
					if (cache_live[j] && (oldest < 0 || cache_age[j] > cache_age[oldest]))
						oldest = j;
				if (oldest >= 0) begin
					cache_live[oldest] = 1'b0;
					cache_age[oldest] = '0;
					cache_fill = cache_fill - CAP_W'(1);
					res.evicted = 1'b1;
				end
			end
			for (int j = 0; j < DEPTH; j++)
				if (hole < 0 && !cache_live[j])
					hole = j;
			for (int j = 0; j < DEPTH; j++)
				if (cache_live[j])
					cache_age[j] = cache_age[j] + AGE_W'(1);
			cache_keys[hole] = k;
			cache_vals[hole] = v;
			cache_live[hole] = 1'b1;
			cache_age[hole] = '0;
			cache_fill = cache_fill + CAP_W'(1);
		end
		return res;
	endfunction

	task automatic issue_request(input stim_row_t row);
		lookup_result_t want;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= (row.kind == ROW_PUT) ? lkv_pkg::REQ_PUT : lkv_pkg::REQ_GET;
		req_if.key <= row.key;
		req_if.value <= row.value;
		do @(posedge clk); while (!req_if.ready);
		want = predict_access(row.kind == ROW_PUT, row.key, row.value);
		if (row.known)
			want = row.want;
		pending_results.push_back(want);
	endtask

	task automatic drain_requests();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		drain_requests();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		cache_cap = cap;
	endtask

	task automatic check_response();
		lookup_result_t want;
		beat_count++;
		if (pending_results.size() == 0) begin
			report_mismatch("response beat with no request outstanding");
			return;
		end
		want = pending_results.pop_front();
		if (rsp_if.hit !== want.hit)
			report_mismatch($sformatf("hit got %b want %b", rsp_if.hit, want.hit));
		if (rsp_if.read_value !== want.read_value)
			report_mismatch($sformatf("read_value got %h want %h",
				rsp_if.read_value, want.read_value));
		if (rsp_if.evicted !== want.evicted)
			report_mismatch($sformatf("evicted got %b want %b", rsp_if.evicted, want.evicted));
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready)
				check_response();
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	initial begin
		stim_row_t        row;
		logic [CAP_W-1:0] cap;
		logic [KEY_W-1:0] key_pool [24];
		int               pool_n;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_if.valid <= 1'b0;
		req_if.req_type <= lkv_pkg::REQ_GET;
		req_if.key <= '0;
		req_if.value <= '0;
		for (int j = 0; j < DEPTH; j++) begin
			cache_live[j] = 1'b0;
			cache_age[j] = '0;
		end
		cache_fill = '0;
		cache_cap = lkv_pkg::CAP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = SRC_IDLE[0];
		snk_idle_pct = SNK_IDLE[0];
		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].kind == ROW_CAP)
				set_capacity(DIRECTED_ROWS[i].value[CAP_W-1:0]);
			else
				issue_request(DIRECTED_ROWS[i]);
		end

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = SRC_IDLE[ph];
			snk_idle_pct = SNK_IDLE[ph];
			for (int seg = 0; seg < 6; seg++) begin
				case (seg)
					0: cap = CAP_W'(31);
					1: cap = CAP_W'(1);
					2: cap = CAP_W'($urandom_range(2, 15));
					3: cap = CAP_W'(0);
					4: cap = CAP_W'(16);
					default: cap = CAP_W'($urandom_range(0, 31));
				endcase
				set_capacity(cap);
				pool_n = ((cap == 0) ? 1 : (cap > DEPTH) ? DEPTH : cap) + $urandom_range(1, 6);
				if (pool_n > 24)
					pool_n = 24;
				for (int i = 0; i < 24; i++) begin
					case ($urandom_range(0, 15))
						0: key_pool[i] = KEY_MIN;
						1: key_pool[i] = KEY_MAX;
						2: key_pool[i] = '0;
						3: key_pool[i] = ALL_ONES;
						default: key_pool[i] = $urandom;
					endcase
				end
				if (seg == 1)
					hold_request = 1'b1;
				for (int n = 0; n < SEG_ITEMS; n++) begin
					// hold the sender until every response is back
					if (seg == 3 && n == SEG_ITEMS / 2)
						drain_requests();
					row.kind = ($urandom_range(0, 99) < 45) ? ROW_PUT : ROW_GET;
					row.key = ($urandom_range(0, 99) < 85) ?
						key_pool[$urandom_range(0, pool_n - 1)] : KEY_W'($urandom);
					row.value = $urandom;
					row.known = 1'b0;
					row.want = RES_NONE;
					issue_request(row);
				end
			end
		end

		drain_requests();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("[lru_key_value_cache] OK");
		else
			$display("[lru_key_value_cache] ERROR");
		$finish;
	end

endmodule
